// ===== rtl/core/u16u8_pkg.sv =====
// shared types, constants and byte-level helpers for the utf-16 to utf-8 encoder
// no dependencies
package u16u8_pkg;

    localparam int unsigned CFG_PERCENT_MODE = 0;
    localparam int unsigned MAX_JOB_BYTES    = 6;

    localparam logic [5:0] HIGH_SURR_TAG = 6'h36;
    localparam logic [5:0] LOW_SURR_TAG  = 6'h37;
    localparam logic [7:0] PERCENT_CHAR  = 8'h25;

    // utf-8 form of one code point
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } utf8_t;

    // work handed from the front to the back: bytes of one input transaction
    typedef struct packed {
        logic [MAX_JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                    nbytes;
        logic                          eot;
        logic                          pmode;
    } job_t;

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.b[0] = cp[7:0];
            r.len  = 3'd1;
        end else if (cp < 21'h800) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.len  = 3'd2;
        end else if (cp < 21'h10000) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.len  = 3'd3;
        end else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.len  = 3'd4;
        end
        return r;
    endfunction

    // unreserved characters: A-Z a-z 0-9 - . _ ~
    function automatic logic passes_plain(input logic [7:0] u);
        return (u >= 8'h41 && u <= 8'h5a) || (u >= 8'h61 && u <= 8'h7a) ||
               (u >= 8'h30 && u <= 8'h39) || u == 8'h2d || u == 8'h2e ||
               u == 8'h5f || u == 8'h7e;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h37 + {4'b0, d});
    endfunction

endpackage

// ===== rtl/core/u16u8_front.sv =====
// front end: accepts utf-16 code units, pairs surrogates, builds utf-8 byte jobs
// depends on u16u8_pkg
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    input  logic        pmode,
    output logic        push,
    output job_t        job
);

    logic [9:0] held_bits_reg, held_bits_next;
    logic       held_valid_reg, held_valid_next;

    logic       is_high, is_low, pair, emit_unit;
    utf8_t      pair_enc, held_enc, unit_enc;
    logic [20:0] pair_cp;

    assign is_high = code_unit[15:10] == HIGH_SURR_TAG;
    assign is_low  = code_unit[15:10] == LOW_SURR_TAG;
    assign pair    = held_valid_reg && is_low;
    assign emit_unit = !(is_high && !end_of_text);

    assign pair_cp  = {1'b0, held_bits_reg, code_unit[9:0]} + 21'h10000;
    assign pair_enc = utf8_enc(pair_cp);
    assign held_enc = utf8_enc({5'b0, HIGH_SURR_TAG, held_bits_reg});
    assign unit_enc = utf8_enc({5'b0, code_unit});

    always_comb begin
        job       = '0;
        job.eot   = end_of_text;
        job.pmode = pmode;
        if (pair) begin
            job.bytes[3:0] = pair_enc.b;
            job.nbytes     = 3'd4;
        end else if (held_valid_reg) begin
            job.bytes[2:0] = held_enc.b[2:0];
            job.bytes[5:3] = unit_enc.b[2:0];
            job.nbytes     = 3'd3 + (emit_unit ? unit_enc.len : 3'd0);
        end else begin
            job.bytes[3:0] = unit_enc.b;
            job.nbytes     = emit_unit ? unit_enc.len : 3'd0;
        end
    end

    assign push = accept && (job.nbytes != 3'd0);

    always_comb begin
        held_bits_next  = held_bits_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            if (!pair && is_high && !end_of_text) begin
                held_bits_next  = code_unit[9:0];
                held_valid_next = 1'b1;
            end else begin
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bits_reg  <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            held_bits_reg  <= held_bits_next;
            held_valid_reg <= held_valid_next;
        end
    end

    a_eot_clears_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_text |=> !held_valid_reg)
        else $error("surrogate still held after end of text");

    a_hold_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !held_valid_reg && is_high && !end_of_text |-> !push)
        else $error("held high surrogate produced output");

endmodule

// ===== rtl/core/u16u8_queue.sv =====
// short job queue between the front and back ends
// depends on u16u8_pkg
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue underflow");

endmodule

// ===== rtl/core/u16u8_back.sv =====
// back end: walks the bytes of each job, percent-expands, drives the output register
// depends on u16u8_pkg
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic [2:0] idx_reg, idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       text_last_reg, text_last_next;

    logic [7:0] cur_byte, cur_value;
    logic       plain, byte_done, job_done, load;

    assign cur_byte  = head_job.bytes[idx_reg];
    assign plain     = !head_job.pmode || passes_plain(cur_byte);
    assign byte_done = plain || (phase_reg == 2'd2);
    assign job_done  = byte_done && (idx_reg == head_job.nbytes - 3'd1);
    assign load      = head_valid && (!valid_reg || m_tready);
    assign pop       = load && job_done;

    always_comb begin
        case (phase_reg)
            2'd0:    cur_value = plain ? cur_byte : PERCENT_CHAR;
            2'd1:    cur_value = hex_digit(cur_byte[7:4]);
            2'd2:    cur_value = hex_digit(cur_byte[3:0]);
            default: cur_value = cur_byte;
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        valid_next     = valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        text_last_next = text_last_reg;
        if (load) begin
            valid_next     = 1'b1;
            data_next      = cur_value;
            last_next      = job_done;
            text_last_next = job_done && head_job.eot;
            if (byte_done) begin
                phase_next = 2'd0;
                idx_next   = job_done ? 3'd0 : idx_reg + 3'd1;
            end else begin
                phase_next = phase_reg + 2'd1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg      <= data_next;
        last_reg      <= last_next;
        text_last_reg <= text_last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = text_last_reg;

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && m_tlast)
        else $error("job retired without run end on output");

    a_text_last_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of text flagged inside a run");

endmodule

// ===== rtl/core/utf16_to_utf8_percent_encoder.sv =====
// top level of the utf-16 to utf-8 / percent encoder
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
//
// usage:
//   input stream: one utf-16 code unit per transaction on s_tdata, s_tlast set on
//   the final unit of a text. output stream: one byte per transaction on m_tdata,
//   m_tlast on the final byte caused by an input transaction, m_tuser on the final
//   byte of the whole text.
//   a high surrogate that does not end the text is held until the next unit arrives
//   and produces no output of its own; lone surrogates come out in the 3-byte form.
//   register 0 (percent_mode) at apb address 0 selects raw utf-8 (0) or
//   percent-encoded ascii (1); write it only while the encoder is idle.
// path: the queue takes the job at the accepting edge, then the output register loads it
// throughput: the byte walker in the back end emits one byte per cycle while m_tready is high,
//   and a unit produces 0 to 18 bytes (e.g. 12 for a percent-encoded surrogate pair);
//   single-byte units stream at one per cycle while the output is not stalled.
// reset: aresetn low for one clock empties the job queue, drops any held
//   surrogate and returns percent_mode to raw utf-8.
// stall: with m_tready low the current byte holds on the output register; the
//   job queue keeps taking input until it is full, then s_tready falls.
module utf16_to_utf8_percent_encoder
    import u16u8_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // end_of_text
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_value
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // [0] text_last
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic percent_mode_reg, percent_mode_next;
    logic cfg_write, cfg_hit;

    logic s_accept;
    logic push, pop, queue_full, head_valid;
    job_t push_job, head_job;

    // register file: one bit, byte address 4*index
    assign pready    = 1'b1;
    assign cfg_hit   = paddr[2:2] == 1'(CFG_PERCENT_MODE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {31'b0, percent_mode_reg} : 32'b0;

    always_comb begin
        percent_mode_next = percent_mode_reg;
        if (cfg_write && cfg_hit) begin
            percent_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            percent_mode_reg <= 1'b0;
        end else begin
            percent_mode_reg <= percent_mode_next;
        end
    end

    // front takes a transaction whenever the queue has a free slot
    assign s_tready = !queue_full;
    assign s_accept = s_tvalid && s_tready;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .code_unit   (s_tdata),
        .end_of_text (s_tlast),
        .pmode       (percent_mode_reg),
        .push        (push),
        .job         (push_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for utf16_to_utf8_percent_encoder: raw and percent-encoded output
// depends on u16u8_pkg and the encoder rtl; no files, plusargs or seeds are read
module tb_top
    import u16u8_pkg::*;
();

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;    // idle time after the last owed byte, ample for the encoder to settle
    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off for the back-pressure test
    localparam int unsigned UNUSED_REG   = 1;     // no register lives here, writes are dropped
    localparam logic [127:0] HEX_GLYPHS  = "0123456789ABCDEF";

    // one output byte as the encoder should present it
    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       text_last;
    } out_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] code_unit
    logic        s_tlast  = 1'b0;  // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_value
    logic        m_tlast;          // run_last
    logic        m_tuser;          // [0] text_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // bytes still owed by the encoder, oldest first
    out_beat_t   pending_bytes[$];
    logic [7:0]  utf8_stage[$];

    // shadow of the encoder state
    logic [9:0]  held_bits = '0;
    logic        held_ok   = 1'b0;
    logic        pct_mode  = 1'b0;

    // idle control shared by the sender and the receiver
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned rx_hold       = 0;
    int unsigned long_hold_cnt  = 0;   // requests raised by the sender
    int unsigned long_hold_seen = 0;   // requests taken up by the receiver

    int unsigned err_cnt   = 0;
    int unsigned n_units   = 0;
    int unsigned n_bytes   = 0;
    int unsigned n_writes  = 0;
    int unsigned cycle_cnt = 0;

    utf16_to_utf8_percent_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_cnt, pending_bytes.size());
            $display("FAILURE");
            $finish;
        end
    end

    // idle lengths: mostly short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] d);
        return HEX_GLYPHS[8*(15 - d) +: 8];
    endfunction

    // adds one byte at the tail of the staging queue
    task automatic stage_byte(input logic [7:0] b);
        utf8_stage.insert(utf8_stage.size(), b);
    endtask

    // appends the utf-8 form of one code point to the staging queue
    task automatic append_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            stage_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            stage_byte(8'hC0 | 8'(cp >> 6));
            stage_byte(8'h80 | 8'(cp & 21'h3f));
        end else if (cp < 21'h10000) begin
            stage_byte(8'hE0 | 8'(cp >> 12));
            stage_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            stage_byte(8'h80 | 8'(cp & 21'h3f));
        end else begin
            stage_byte(8'hF0 | 8'(cp >> 18));
            stage_byte(8'h80 | 8'((cp >> 12) & 21'h3f));
            stage_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            stage_byte(8'h80 | 8'(cp & 21'h3f));
        end
    endtask

    // works out the bytes one accepted code unit owes and queues them
    task automatic predict_unit(input logic [15:0] cu, input logic eot);
        logic [7:0] chars[$];
        out_beat_t  beat;
        int         i;
        utf8_stage.delete();
        if (held_ok && cu[15:10] == LOW_SURR_TAG) begin
            // completes a pair: one supplementary code point
            held_ok = 1'b0;
            append_utf8((({11'd0, held_bits} << 10) | {11'd0, cu[9:0]}) + 21'h10000);
        end else begin
            // a held high surrogate not followed by a low one goes out alone first
            if (held_ok) begin
                held_ok = 1'b0;
                append_utf8({5'd0, HIGH_SURR_TAG, held_bits});
            end
            if (cu[15:10] == HIGH_SURR_TAG && !eot) begin
                held_bits = cu[9:0];
                held_ok   = 1'b1;
            end else begin
                append_utf8({5'd0, cu});
            end
        end
        if (eot)
            held_ok = 1'b0;
        for (i = 0; i < utf8_stage.size(); i++) begin
            if (!pct_mode || is_unreserved(utf8_stage[i])) begin
                chars.insert(chars.size(), utf8_stage[i]);
            end else begin
                chars.insert(chars.size(), PERCENT_CHAR);
                chars.insert(chars.size(), hex_glyph(utf8_stage[i][7:4]));
                chars.insert(chars.size(), hex_glyph(utf8_stage[i][3:0]));
            end
        end
        for (i = 0; i < chars.size(); i++) begin
            beat.value     = chars[i];
            beat.run_last  = (i == chars.size() - 1);
            beat.text_last = beat.run_last & eot;
            pending_bytes.insert(pending_bytes.size(), beat);
        end
        n_units++;
    endtask

    // offers one code unit, waits for the transaction, then maybe idles
    task automatic send_unit(input logic [15:0] cu, input logic eot);
        s_tvalid <= 1'b1;
        s_tdata  <= cu;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        predict_unit(cu, eot);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    // setup then access phase; the register takes the value at the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == 3'(4 * CFG_PERCENT_MODE))
            pct_mode = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        n_writes++;
    endtask

    // sender pauses until every owed byte has arrived, then a little longer
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        apb_write(3'(4 * CFG_PERCENT_MODE), {31'($urandom), mode});
    endtask

    // texts of random length, mostly well-formed with a share of stray surrogates and noise
    task automatic send_random_texts(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned r;
        logic        last;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                last = (k == len - 1);
                r    = $urandom_range(0, 99);
                if (r < 30) begin
                    send_unit(16'($urandom_range(0, 16'h7F)), last);
                end else if (r < 45) begin
                    send_unit(16'($urandom_range(16'h80, 16'h7FF)), last);
                end else if (r < 60) begin
                    send_unit(16'($urandom_range(16'h800, 16'hFFFF)), last);
                end else if (r < 80) begin
                    // well-formed pair, the low half may close the text
                    send_unit({HIGH_SURR_TAG, 10'($urandom_range(0, 1023))}, 1'b0);
                    send_unit({LOW_SURR_TAG, 10'($urandom_range(0, 1023))}, last);
                    sent++;
                end else if (r < 85) begin
                    send_unit({HIGH_SURR_TAG, 10'($urandom_range(0, 1023))}, last);
                end else if (r < 90) begin
                    send_unit({LOW_SURR_TAG, 10'($urandom_range(0, 1023))}, last);
                end else begin
                    send_unit(16'($urandom), last);
                end
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (long_hold_seen != long_hold_cnt) begin
            long_hold_seen = long_hold_cnt;
            rx_hold        = LONG_HOLD - 1;
            m_tready      <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold   = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // each output transaction against the oldest owed byte
    out_beat_t got_exp;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_bytes++;
            if (pending_bytes.size() == 0) begin
                $error("output transaction with nothing owed: out_value %02h", m_tdata);
                err_cnt++;
            end else begin
                got_exp = pending_bytes.pop_front();
                if (m_tdata !== got_exp.value) begin
                    $error("out_value: expected %02h, actual %02h", got_exp.value, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== got_exp.run_last) begin
                    $error("run_last: expected %0b, actual %0b", got_exp.run_last, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== got_exp.text_last) begin
                    $error("text_last: expected %0b, actual %0b", got_exp.text_last, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // code units at every utf-8 length boundary, raw output
    task automatic test_raw_widths();
        set_mode(1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        wait_drained();
    endtask

    // pairs at both ends of the range, and every way a surrogate can be left alone
    task automatic test_surrogates();
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hD83D, 1'b1);    // high half closing the text goes out at once
        send_unit(16'hDA00, 1'b0);    // held, then displaced by another high half
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hDC12, 1'b0);
        send_unit(16'hD800, 1'b0);    // held, then followed by plain ascii
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDC00, 1'b1);    // low half with nothing before it
        wait_drained();
    endtask

    // mode changes while a high half is held: the pair follows the new mode
    task automatic test_mode_switch_held();
        send_unit(16'hDBFF, 1'b0);
        wait_drained();
        set_mode(1'b1);
        send_unit(16'hDFFF, 1'b1);    // twelve characters for the one pair
        wait_drained();
    endtask

    // unreserved and reserved bytes in percent mode, and a write to an empty address
    task automatic test_percent_chars();
        send_unit(16'h002D, 1'b0);
        send_unit(16'h007E, 1'b0);
        send_unit(16'h0020, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h00E9, 1'b1);
        wait_drained();
        apb_write(3'(4 * UNUSED_REG), 32'h0);    // must leave percent mode alone
        send_unit(16'h0025, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_mix(input logic mode, input int unsigned n_items);
        set_mode(mode);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        send_random_texts(n_items);
        wait_drained();
    endtask

    // receiver holds off long enough for the queue to fill and s_tready to drop
    task automatic test_backpressure();
        set_mode(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_cnt++;
        send_random_texts(30);
        wait_drained();
        send_random_texts(10);
        wait_drained();
    endtask

    // no idling on either side
    task automatic test_full_rate();
        set_mode(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_texts(60);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rx_idle_pct = 20;
        test_raw_widths();
        test_surrogates();
        test_mode_switch_held();
        test_percent_chars();
        test_random_mix(1'b0, 100);
        test_random_mix(1'b1, 100);
        test_backpressure();
        test_full_rate();
        $display("%0d code units in, %0d bytes checked, %0d register writes",
                 n_units, n_bytes, n_writes);
        $display("raw and percent output, pairs, stray surrogates, long output stall covered");
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
